>>> hdl/dsnc_pkg.sv
// ----------------------------------------------------------------------------
// dsnc_pkg
// Shared widths, character codes and limits for the DOS 8.3 short-name
// checker.
// ----------------------------------------------------------------------------
package dsnc_pkg;

  localparam int UNIT_W       = 16;
  localparam int BASE_CNT_W   = 4;
  localparam int EXT_CNT_W    = 3;
  localparam int SEEN_W       = 2;

  localparam int BASE_MAX_DEF = 8;
  localparam int EXT_MAX_DEF  = 3;

  localparam logic [UNIT_W-1:0] CHAR_DOT   = 16'h002E;
  localparam logic [UNIT_W-1:0] CHAR_SPACE = 16'h0020;
  localparam logic [UNIT_W-1:0] PRINT_LO   = 16'h0020;
  localparam logic [UNIT_W-1:0] PRINT_HI   = 16'h007E;

  localparam logic [SEEN_W-1:0] SEEN_SAT   = '1;

  typedef logic [UNIT_W-1:0] unit_t;

  function automatic logic is_reserved(input unit_t c);
    logic r;
    case (c) inside
      16'h0022, 16'h002A, 16'h002B, 16'h002C, 16'h002F, 16'h003A, 16'h003B,
      16'h003C, 16'h003D, 16'h003E, 16'h003F, 16'h005B, 16'h005C, 16'h005D,
      16'h007C: r = 1'b1;
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/dos_short_name_checker.sv
// ----------------------------------------------------------------------------
// dos_short_name_checker
// Checks a name, one UTF-16 word per transfer, against the DOS 8.3 rules
// and returns one verdict per name.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                | moves
//  in      | input     | in_valid/in_ready, in_code_unit,     | one name unit
//          |           | in_last_unit, in_empty_name          |
//  out     | output    | out_valid/out_ready, out_legal       | one verdict
//
//  One word is accepted per cycle unless a last or empty-name word waits
//  in the input register for out to be free. The verdict is offered on out
//  from the result register, after the last word passes the input register.
//  rst_n is synchronous, active low, and clears all control state.
//  A verdict held on out stalls the word that would produce the next verdict,
//  and the words behind it; words before it keep flowing.
// ----------------------------------------------------------------------------
module dos_short_name_checker #(
  parameter int BASE_MAX = dsnc_pkg::BASE_MAX_DEF,
  parameter int EXT_MAX  = dsnc_pkg::EXT_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dsnc_pkg::unit_t     in_code_unit,
  input  logic                in_last_unit,
  input  logic                in_empty_name,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_legal
);
  import dsnc_pkg::*;

  localparam logic [BASE_CNT_W-1:0] BASE_LIM = BASE_CNT_W'(BASE_MAX);
  localparam logic [EXT_CNT_W-1:0]  EXT_LIM  = EXT_CNT_W'(EXT_MAX);

  // input register
  logic                  s1_valid_r;
  unit_t                 s1_code_r;
  logic                  s1_last_r;
  logic                  s1_empty_r;

  // name state
  logic                  dot_seen_r,   dot_seen_nxt;
  logic [BASE_CNT_W-1:0] base_count_r, base_count_nxt;
  logic [EXT_CNT_W-1:0]  ext_count_r,  ext_count_nxt;
  logic                  rejected_r,   rejected_nxt;
  logic [SEEN_W-1:0]     units_seen_r, units_seen_nxt;
  logic                  only_dots_r,  only_dots_nxt;

  // result register
  logic                  out_valid_r;
  logic                  out_legal_r;

  // updated values after taking the unit in s1
  logic                  t_dot;
  logic [BASE_CNT_W-1:0] t_base;
  logic [EXT_CNT_W-1:0]  t_ext;
  logic                  t_rej;
  logic [SEEN_W-1:0]     t_seen;
  logic                  t_only;
  logic                  is_dot;
  logic                  is_bad;
  logic                  finish;
  logic                  verdict;
  logic                  out_free;
  logic                  s1_adv;

  assign out_free = !out_valid_r || out_ready;
  assign finish   = s1_last_r || s1_empty_r;
  assign s1_adv   = s1_valid_r && (!finish || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    is_dot = (s1_code_r == CHAR_DOT);
    is_bad = (s1_code_r < PRINT_LO) || (s1_code_r > PRINT_HI) ||
             (s1_code_r == CHAR_SPACE) || is_reserved(s1_code_r);
    t_dot  = dot_seen_r;
    t_base = base_count_r;
    t_ext  = ext_count_r;
    t_rej  = rejected_r;
    t_seen = (units_seen_r == SEEN_SAT) ? units_seen_r : units_seen_r + 1'b1;
    t_only = only_dots_r && is_dot;
    if (is_dot) begin
      if (dot_seen_r || (base_count_r == '0)) t_rej = 1'b1;
      t_dot = 1'b1;
    end else if (is_bad) begin
      t_rej = 1'b1;
    end else if (dot_seen_r) begin
      if (ext_count_r >= EXT_LIM) t_rej = 1'b1;
      else                        t_ext = ext_count_r + 1'b1;
    end else begin
      if (base_count_r >= BASE_LIM) t_rej = 1'b1;
      else                          t_base = base_count_r + 1'b1;
    end

    if (s1_empty_r) begin
      verdict = 1'b0;
    end else if (t_only && (t_seen == SEEN_W'(1) || t_seen == SEEN_W'(2))) begin
      verdict = 1'b1;
    end else begin
      verdict = !t_rej && (t_base != '0) && (!t_dot || (t_ext != '0));
    end

    if (finish) begin
      dot_seen_nxt   = 1'b0;
      base_count_nxt = '0;
      ext_count_nxt  = '0;
      rejected_nxt   = 1'b0;
      units_seen_nxt = '0;
      only_dots_nxt  = 1'b1;
    end else begin
      dot_seen_nxt   = t_dot;
      base_count_nxt = t_base;
      ext_count_nxt  = t_ext;
      rejected_nxt   = t_rej;
      units_seen_nxt = t_seen;
      only_dots_nxt  = t_only;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      dot_seen_r   <= 1'b0;
      base_count_r <= '0;
      ext_count_r  <= '0;
      rejected_r   <= 1'b0;
      units_seen_r <= '0;
      only_dots_r  <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s1_adv) begin
        dot_seen_r   <= dot_seen_nxt;
        base_count_r <= base_count_nxt;
        ext_count_r  <= ext_count_nxt;
        rejected_r   <= rejected_nxt;
        units_seen_r <= units_seen_nxt;
        only_dots_r  <= only_dots_nxt;
      end
      if (s1_adv && finish)  out_valid_r <= 1'b1;
      else if (out_ready)    out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_code_r  <= in_code_unit;
      s1_last_r  <= in_last_unit;
      s1_empty_r <= in_empty_name;
    end
    if (s1_adv && finish) out_legal_r <= verdict;
  end

  assign out_valid = out_valid_r;
  assign out_legal = out_legal_r;

  a_reset_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && finish) |=> (units_seen_r == '0) && only_dots_r && !rejected_r &&
                           !dot_seen_r && (base_count_r == '0) && (ext_count_r == '0))
    else $error("state not cleared after verdict");

  a_base_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (base_count_r <= BASE_LIM) && (ext_count_r <= EXT_LIM))
    else $error("counter beyond its limit");

  a_ext_needs_dot: assert property (@(posedge clk) disable iff (!rst_n)
    (ext_count_r != '0) |-> dot_seen_r)
    else $error("extension counted without a dot");

  a_fresh_name: assert property (@(posedge clk) disable iff (!rst_n)
    (units_seen_r == '0) |-> (!dot_seen_r && (base_count_r == '0) && only_dots_r))
    else $error("name state set with no units seen");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(s1_adv && finish))
    else $error("pending verdict overwritten");

endmodule
